// ===== rtl/lkv_pkg.sv =====
package lkv_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int KEY_W   = 32;
   localparam int VAL_W   = 32;
   localparam int CAP_W   = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_PUT = 1'b1;

   typedef struct packed {
      logic load;     // capture the accepted transaction and its hit vector
      logic execute;  // apply the update and write the result register
   } lkv_cmd_type;

   typedef struct packed {
      logic out_free; // result register can take a new result this cycle
   } lkv_status_type;

endpackage

// ===== rtl/lkv_ctrl.sv =====
module lkv_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  lkv_pkg::lkv_status_type status,
   output lkv_pkg::lkv_cmd_type    cmd
);
   import lkv_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in    = state_ff;
      cmd.load    = 1'b0;
      cmd.execute = 1'b0;
      req_stall   = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.out_free) begin
               cmd.execute = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/lkv_datapath.sv =====
module lkv_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_func,
   input  logic [lkv_pkg::KEY_W-1:0]     req_lookup_key,
   input  logic [lkv_pkg::VAL_W-1:0]     req_write_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_found,
   output logic [lkv_pkg::VAL_W-1:0]     rsp_read_value,
   input  logic                          csr_write_enable,
   input  logic [lkv_pkg::CAP_W-1:0]     csr_write_data,
   input  lkv_pkg::lkv_cmd_type          cmd,
   output lkv_pkg::lkv_status_type       status
);
   import lkv_pkg::*;

   localparam int CMP_W = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;

   // entry storage
   logic [KEY_W-1:0] key_ff  [ENTRIES];
   logic [KEY_W-1:0] key_in  [ENTRIES];
   logic [VAL_W-1:0] data_ff [ENTRIES];
   logic [VAL_W-1:0] data_in [ENTRIES];
   logic [IDX_W-1:0] rank_ff [ENTRIES];
   logic [IDX_W-1:0] rank_in [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   logic [ENTRIES-1:0] valid_in;
   logic [CNT_W-1:0]   occ_ff;
   logic [CNT_W-1:0]   occ_in;
   logic [CAP_W-1:0]   cap_ff;

   // captured transaction
   logic               func_ff;
   logic [KEY_W-1:0]   lkey_ff;
   logic [VAL_W-1:0]   wval_ff;
   logic [ENTRIES-1:0] hit_ff;
   logic [ENTRIES-1:0] hit_in;

   // result register
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               found_ff;
   logic               found_in;
   logic [VAL_W-1:0]   rval_ff;
   logic [VAL_W-1:0]   rval_in;

   logic [CMP_W-1:0]   cap_x;
   logic [CMP_W-1:0]   eff_cap;
   logic               full;
   logic               hit_any;
   logic               is_put;
   logic               do_insert;
   logic               active;
   logic [ENTRIES-1:0] free_oh;
   logic [ENTRIES-1:0] victim_oh;
   logic [ENTRIES-1:0] sel_oh;
   logic [IDX_W-1:0]   sel_rank;
   logic [IDX_W:0]     thr;
   logic [IDX_W-1:0]   lru_rank;
   logic [VAL_W-1:0]   hit_data;

   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         hit_in[i] = valid_ff[i] && (key_ff[i] == req_lookup_key);
      end
   end

   always_comb begin
      cap_x = CMP_W'(cap_ff);
      if (cap_x == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_x > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = cap_x;
      end
      full = CMP_W'(occ_ff) >= eff_cap;
   end

   // ranks of valid entries are distinct 0..occ-1, so the LRU entry has rank occ-1
   assign lru_rank = IDX_W'(occ_ff - CNT_W'(1));
   assign free_oh  = ~valid_ff & (valid_ff + ENTRIES'(1));

   always_comb begin
      hit_any   = |hit_ff;
      is_put    = (func_ff == FUNC_PUT);
      do_insert = is_put && !hit_any && !full;
      active    = hit_any || is_put;
      for (int i = 0; i < ENTRIES; i++) begin
         victim_oh[i] = valid_ff[i] && (rank_ff[i] == lru_rank);
      end
      if (hit_any) begin
         sel_oh = hit_ff;
      end else if (full) begin
         sel_oh = victim_oh;
      end else begin
         sel_oh = free_oh;
      end
      sel_rank = '0;
      hit_data = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         sel_rank = sel_rank | (rank_ff[i] & {IDX_W{sel_oh[i]}});
         hit_data = hit_data | (data_ff[i] & {VAL_W{hit_ff[i]}});
      end
      // a fresh insert ages every valid entry
      thr = do_insert ? {1'b1, {IDX_W{1'b0}}} : {1'b0, sel_rank};
   end

   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         key_in[i]  = key_ff[i];
         data_in[i] = data_ff[i];
         rank_in[i] = rank_ff[i];
         if (cmd.execute && active) begin
            if (sel_oh[i]) begin
               rank_in[i] = '0;
               if (is_put) begin
                  data_in[i] = wval_ff;
               end
               if (is_put && !hit_any) begin
                  key_in[i] = lkey_ff;
               end
               if (do_insert) begin
                  valid_in[i] = 1'b1;
               end
            end else if (valid_ff[i] && ({1'b0, rank_ff[i]} < thr)) begin
               rank_in[i] = IDX_W'(rank_ff[i] + IDX_W'(1));
            end
         end
      end
      if (cmd.execute && do_insert) begin
         occ_in = CNT_W'(occ_ff + CNT_W'(1));
      end
   end

   always_comb begin
      rsp_valid_in = cmd.execute || (rsp_valid_ff && rsp_stall);
      found_in     = found_ff;
      rval_in      = rval_ff;
      if (cmd.execute) begin
         found_in = hit_any;
         rval_in  = (!is_put && hit_any) ? hit_data : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         occ_ff       <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
         if (csr_write_enable) begin
            cap_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         key_ff[i]  <= key_in[i];
         data_ff[i] <= data_in[i];
      end
      found_ff <= found_in;
      rval_ff  <= rval_in;
      if (cmd.load) begin
         func_ff <= req_func;
         lkey_ff <= req_lookup_key;
         wval_ff <= req_write_value;
         hit_ff  <= hit_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = found_ff;
   assign rsp_read_value = rval_ff;

endmodule

// ===== rtl/lru_key_value_cache_top.sv =====
// Fully associative key/value cache with least recently used replacement,
// up to 16 entries; csr_write_data sets how many may be held (0 acts as 1,
// above 16 acts as 16). A get (func 0) returns found and the stored value,
// or found 0 and value 0 on a miss; a put (func 1) updates or inserts and
// always returns value 0, found telling whether the key was present. In
// the accept cycle the key is compared against all entries at once; the
// ranks, entry and result register are then updated in the execute state,
// which waits while a stalled result holds the result register, and no new
// transaction is taken until it ends. No clearing pass is needed after
// reset. Write the capacity only while the block is idle.
module lru_key_value_cache_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_func,
   input  logic [lkv_pkg::KEY_W-1:0] req_lookup_key,
   input  logic [lkv_pkg::VAL_W-1:0] req_write_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_found,
   output logic [lkv_pkg::VAL_W-1:0] rsp_read_value,
   input  logic                      csr_write_enable,
   input  logic [lkv_pkg::CAP_W-1:0] csr_write_data
);
   import lkv_pkg::*;

   lkv_cmd_type    cmd;
   lkv_status_type status;

   lkv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lkv_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_func         (req_func),
      .req_lookup_key   (req_lookup_key),
      .req_write_value  (req_write_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_read_value   (rsp_read_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

// ===== rtl/lkv_checker.sv =====
module lkv_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic                      rsp_found,
   input logic [lkv_pkg::VAL_W-1:0] rsp_read_value
);
   import lkv_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_found) && $stable(rsp_read_value))
      else $error("stalled result changed");

   // one transaction in flight: the cycle after an accept is always stalled
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("transaction accepted back to back");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_read_value == '0)
      else $error("miss returned nonzero value");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind lru_key_value_cache_top lkv_checker u_lkv_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_found      (rsp_found),
   .rsp_read_value (rsp_read_value)
);
